[sv/fbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants for the FAT boot sector recognizer.
// ----------------------------------------------------------------------------
package fbs_pkg;

  // stream position counter width
  localparam int LENGTH_BITS = 48;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

  // width used to compare stream length against image size
  localparam int CMP_W = 64;
  localparam int BYTES_W = 48;

  // byte positions inside the boot sector
  localparam int POS_JUMP_FIRST  = 0;
  localparam int POS_JUMP_THIRD  = 2;
  localparam int POS_SECTOR      = 11;
  localparam int POS_CLUSTER     = 13;
  localparam int POS_RESERVED    = 14;
  localparam int POS_COPIES      = 16;
  localparam int POS_ROOT        = 17;
  localparam int POS_TOTAL_SHORT = 19;
  localparam int POS_MEDIA       = 21;
  localparam int POS_TABLE_SHORT = 22;
  localparam int POS_TOTAL_LONG  = 32;
  localparam int POS_TABLE_LONG  = 36;
  localparam int POS_LABEL_LO    = 54;
  localparam int POS_LABEL_HI    = 82;

  // stream length thresholds
  localparam int LEN_MIN       = 64;
  localparam int LEN_TABLE32   = 72;
  localparam int LEN_LABEL_LO  = 62;
  localparam int LEN_LABEL_HI  = 90;

  // signature bytes
  localparam logic [7:0] JMP_SHORT = 8'hEB;
  localparam logic [7:0] OP_NOP    = 8'h90;
  localparam logic [7:0] JMP_NEAR  = 8'hE9;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_T    = 8'h54;

  // plausibility limits
  localparam logic [7:0]  MEDIA_FIXED  = 8'hF0;
  localparam logic [7:0]  MEDIA_LOW    = 8'hF8;
  localparam logic [7:0]  CLUSTER_MAX  = 8'd128;
  localparam logic [7:0]  COPIES_MAX   = 8'd4;
  localparam logic [15:0] SECTOR_512   = 16'd512;
  localparam logic [15:0] SECTOR_1K    = 16'd1024;
  localparam logic [15:0] SECTOR_2K    = 16'd2048;
  localparam logic [15:0] SECTOR_4K    = 16'd4096;
  localparam int          DIR_ENTRY_BYTES = 32;

  // cluster count limits for the type decision
  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // divider
  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_FAT12   = 2'd1,
    KIND_FAT16   = 2'd2,
    KIND_FAT32   = 2'd3
  } fat_kind_t;

  // one classified stream, handed from front to back
  typedef struct packed {
    logic                   truncated;
    logic                   sig;
    logic                   plaus;
    logic [15:0]            sector;
    logic [7:0]             cluster;
    logic [15:0]            reserved;
    logic [7:0]             copies;
    logic [15:0]            root_ent;
    logic [31:0]            total;
    logic [31:0]            fatsz;
    logic [LENGTH_BITS-1:0] len;
  } fbs_rec_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/fat_boot_sector_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_boot_sector_recognizer
// Parses the BIOS parameter block of a byte stream and reports FAT identity.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, data_byte, last): one byte of the image
// per transaction, starting at the boot sector; last flags the final byte.
// Bytes are taken one per cycle; in_ready drops only while the record queue
// (two entries) is full.
// Output channel (out_valid/out_ready, result fields): one transaction per
// stream, produced after the byte carrying last.
// A stream under 64 bytes goes straight to the result; longer streams wait
// on up to two passes through the shared 32-step bit-serial divider (root
// directory sectors, cluster count).
// A stream shorter than the result latency keeps the queue filling; longer
// streams do not stall the input unless the receiver stalls.
// While the receiver stalls, the result holds in the output register, the
// back end finishes the next record and waits, and the front keeps taking
// bytes until the queue fills.
// Reset clears the position counter, captured fields, queue and result valid.
// ----------------------------------------------------------------------------
module fat_boot_sector_recognizer import fbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               signature_match,
  output logic               plausible,
  output logic               truncated,
  output logic [1:0]         fat_kind,
  output logic [15:0]        sector_bytes,
  output logic [7:0]         cluster_sectors,
  output logic [15:0]        reserved_count,
  output logic [7:0]         table_copies,
  output logic [31:0]        table_sectors,
  output logic [31:0]        sector_total,
  output logic [BYTES_W-1:0] image_bytes,
  output logic [BYTES_W-1:0] extent_length
);

  fbs_rec_t push_rec, head;
  logic     push, pop, q_full, q_empty;

  fbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .rec       (push_rec)
  );

  fbs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  fbs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .signature_match (signature_match),
    .plausible       (plausible),
    .truncated       (truncated),
    .fat_kind        (fat_kind),
    .sector_bytes    (sector_bytes),
    .cluster_sectors (cluster_sectors),
    .reserved_count  (reserved_count),
    .table_copies    (table_copies),
    .table_sectors   (table_sectors),
    .sector_total    (sector_total),
    .image_bytes     (image_bytes),
    .extent_length   (extent_length)
  );

endmodule

[sv/fbs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbs_front
// Captures boot sector fields by byte position and classifies the stream
// on its last byte, pushing one record into the queue.
// ----------------------------------------------------------------------------
module fbs_front import fbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] data_byte,
  input  logic     last,
  input  logic     q_full,
  output logic     push,
  output fbs_rec_t rec
);

  logic [LENGTH_BITS-1:0] pos;
  logic [7:0]  jump_first, jump_third, cluster_size_reg, copies_reg, media_reg;
  logic [15:0] sector_size_reg, reserved_reg, root_entries_reg;
  logic [15:0] total_short_reg, table_short_reg;
  logic [31:0] total_long_reg, table_long_reg;
  logic        label_seen, label_high;

  logic [7:0]  jump_first_next, jump_third_next, cluster_size_next;
  logic [7:0]  copies_next, media_next;
  logic [15:0] sector_size_next, reserved_next, root_entries_next;
  logic [15:0] total_short_next, table_short_next;
  logic [31:0] total_long_next, table_long_next;
  logic        label_seen_next, label_high_next;

  logic                   accept;
  logic [LENGTH_BITS-1:0] len;
  logic [31:0]            total, fat32;
  logic                   jump_ok, bps_ok, spc_ok, fats_ok, media_ok;

  function automatic logic at_pos(logic [LENGTH_BITS-1:0] p, int k);
    return p == LENGTH_BITS'(k);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last;

  // field capture including the current byte
  always_comb begin
    jump_first_next   = jump_first;
    jump_third_next   = jump_third;
    sector_size_next  = sector_size_reg;
    cluster_size_next = cluster_size_reg;
    reserved_next     = reserved_reg;
    copies_next       = copies_reg;
    root_entries_next = root_entries_reg;
    total_short_next  = total_short_reg;
    media_next        = media_reg;
    table_short_next  = table_short_reg;
    total_long_next   = total_long_reg;
    table_long_next   = table_long_reg;
    label_seen_next   = label_seen;
    label_high_next   = label_high;

    if (at_pos(pos, POS_JUMP_FIRST)) jump_first_next = data_byte;
    if (at_pos(pos, POS_JUMP_THIRD)) jump_third_next = data_byte;
    if (at_pos(pos, POS_SECTOR)) sector_size_next[7:0] = data_byte;
    if (at_pos(pos, POS_SECTOR + 1)) sector_size_next[15:8] = data_byte;
    if (at_pos(pos, POS_CLUSTER)) cluster_size_next = data_byte;
    if (at_pos(pos, POS_RESERVED)) reserved_next[7:0] = data_byte;
    if (at_pos(pos, POS_RESERVED + 1)) reserved_next[15:8] = data_byte;
    if (at_pos(pos, POS_COPIES)) copies_next = data_byte;
    if (at_pos(pos, POS_ROOT)) root_entries_next[7:0] = data_byte;
    if (at_pos(pos, POS_ROOT + 1)) root_entries_next[15:8] = data_byte;
    if (at_pos(pos, POS_TOTAL_SHORT)) total_short_next[7:0] = data_byte;
    if (at_pos(pos, POS_TOTAL_SHORT + 1)) total_short_next[15:8] = data_byte;
    if (at_pos(pos, POS_MEDIA)) media_next = data_byte;
    if (at_pos(pos, POS_TABLE_SHORT)) table_short_next[7:0] = data_byte;
    if (at_pos(pos, POS_TABLE_SHORT + 1)) table_short_next[15:8] = data_byte;

    // 32-bit fields: aligned groups of four bytes
    if (pos[LENGTH_BITS-1:2] == (LENGTH_BITS-2)'(POS_TOTAL_LONG / 4))
      total_long_next[{pos[1:0], 3'b000} +: 8] = data_byte;
    if (pos[LENGTH_BITS-1:2] == (LENGTH_BITS-2)'(POS_TABLE_LONG / 4))
      table_long_next[{pos[1:0], 3'b000} +: 8] = data_byte;

    // "FAT" labels
    if (at_pos(pos, POS_LABEL_LO)) label_seen_next = (data_byte == CHAR_F);
    else if (at_pos(pos, POS_LABEL_LO + 1)) label_seen_next = label_seen && (data_byte == CHAR_A);
    else if (at_pos(pos, POS_LABEL_LO + 2)) label_seen_next = label_seen && (data_byte == CHAR_T);
    if (at_pos(pos, POS_LABEL_HI)) label_high_next = (data_byte == CHAR_F);
    else if (at_pos(pos, POS_LABEL_HI + 1)) label_high_next = label_high && (data_byte == CHAR_A);
    else if (at_pos(pos, POS_LABEL_HI + 2)) label_high_next = label_high && (data_byte == CHAR_T);
  end

  // classification of the finished stream
  always_comb begin
    len      = (pos != POS_MAX) ? pos + 1'b1 : POS_MAX;
    total    = (total_short_next != 16'd0) ? 32'(total_short_next) : total_long_next;
    fat32    = (len >= LENGTH_BITS'(LEN_TABLE32)) ? table_long_next : 32'd0;
    jump_ok  = (jump_first_next == JMP_SHORT && jump_third_next == OP_NOP) ||
               (jump_first_next == JMP_NEAR);
    bps_ok   = sector_size_next == SECTOR_512 || sector_size_next == SECTOR_1K ||
               sector_size_next == SECTOR_2K || sector_size_next == SECTOR_4K;
    spc_ok   = cluster_size_next != 8'd0 && cluster_size_next <= CLUSTER_MAX &&
               (cluster_size_next & (cluster_size_next - 8'd1)) == 8'd0;
    fats_ok  = copies_next != 8'd0 && copies_next <= COPIES_MAX;
    media_ok = media_next == MEDIA_FIXED || media_next >= MEDIA_LOW;

    rec.truncated = len < LENGTH_BITS'(LEN_MIN);
    rec.sig       = jump_ok &&
                    ((len >= LENGTH_BITS'(LEN_LABEL_LO) && label_seen_next) ||
                     (len >= LENGTH_BITS'(LEN_LABEL_HI) && label_high_next));
    rec.plaus     = bps_ok && spc_ok && fats_ok && media_ok && total != 32'd0;
    rec.sector    = sector_size_next;
    rec.cluster   = cluster_size_next;
    rec.reserved  = reserved_next;
    rec.copies    = copies_next;
    rec.root_ent  = root_entries_next;
    rec.total     = total;
    rec.fatsz     = (table_short_next != 16'd0) ? 32'(table_short_next) : fat32;
    rec.len       = len;
  end

  // capture registers; cleared after the last byte of a stream
  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos              <= '0;
      jump_first       <= '0;
      jump_third       <= '0;
      sector_size_reg  <= '0;
      cluster_size_reg <= '0;
      reserved_reg     <= '0;
      copies_reg       <= '0;
      root_entries_reg <= '0;
      total_short_reg  <= '0;
      media_reg        <= '0;
      table_short_reg  <= '0;
      total_long_reg   <= '0;
      table_long_reg   <= '0;
      label_seen       <= 1'b0;
      label_high       <= 1'b0;
    end else if (accept) begin
      if (pos != POS_MAX) pos <= pos + 1'b1;
      jump_first       <= jump_first_next;
      jump_third       <= jump_third_next;
      sector_size_reg  <= sector_size_next;
      cluster_size_reg <= cluster_size_next;
      reserved_reg     <= reserved_next;
      copies_reg       <= copies_next;
      root_entries_reg <= root_entries_next;
      total_short_reg  <= total_short_next;
      media_reg        <= media_next;
      table_short_reg  <= table_short_next;
      total_long_reg   <= total_long_next;
      table_long_reg   <= table_long_next;
      label_seen       <= label_seen_next;
      label_high       <= label_high_next;
    end
  end

endmodule

[sv/fbs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbs_fifo
// Short record queue between the capture front and the compute back.
// ----------------------------------------------------------------------------
module fbs_fifo import fbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fbs_rec_t push_rec,
  input  logic     pop,
  output fbs_rec_t head,
  output logic     full,
  output logic     empty
);

  fbs_rec_t              entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push, do_pop;

  assign full    = count == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

[sv/fbs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbs_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module fbs_div import fbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem, dvs, rem_next;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy, done;
  logic [DIVISOR_W:0]   shifted;
  logic                 take;

  // one restoring step
  always_comb begin
    shifted  = {rem, quo[DIV_W-1]};
    take     = shifted >= {1'b0, dvs};
    rem_next = take ? DIVISOR_W'(shifted - {1'b0, dvs}) : shifted[DIVISOR_W-1:0];
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo   <= req.dividend;
        rem   <= '0;
        dvs   <= req.divisor;
        count <= DIV_CNT_W'(DIV_W);
        busy  <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[DIV_W-2:0], take};
        rem   <= rem_next;
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/fbs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbs_back
// Takes classified records from the queue, computes image size, root and
// data sectors and the cluster count unless truncated; holds the result for the receiver.
// ----------------------------------------------------------------------------
module fbs_back import fbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fbs_rec_t           head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               signature_match,
  output logic               plausible,
  output logic               truncated,
  output logic [1:0]         fat_kind,
  output logic [15:0]        sector_bytes,
  output logic [7:0]         cluster_sectors,
  output logic [15:0]        reserved_count,
  output logic [7:0]         table_copies,
  output logic [31:0]        table_sectors,
  output logic [31:0]        sector_total,
  output logic [BYTES_W-1:0] image_bytes,
  output logic [BYTES_W-1:0] extent_length
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ROOT, ST_ROOT_WAIT, ST_DATA, ST_CLUS, ST_CLUS_WAIT, ST_FINISH
  } state_t;

  state_t             state;
  fbs_rec_t           rec;
  logic [BYTES_W-1:0] image;
  logic [31:0]        fat_prod, base_sum, datasec, clusters;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [31:0]        root_num;
  logic [CMP_W-1:0]   image_w, len_w, ext_w;
  fat_kind_t          kind;
  logic               load;

  fbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pop  = (state == ST_IDLE) && !empty;
  assign load = (state == ST_FINISH) && (!out_valid || out_ready);

  // root directory numerator, extent choice and type decision
  always_comb begin
    root_num = 32'(rec.root_ent) * 32'(DIR_ENTRY_BYTES) + 32'(rec.sector) - 32'd1;
    image_w  = CMP_W'(image);
    len_w    = CMP_W'(rec.len);
    ext_w    = (image_w != '0 && image_w <= len_w) ? image_w : len_w;
    if (clusters < FAT12_LIMIT) kind = KIND_FAT12;
    else if (clusters < FAT16_LIMIT) kind = KIND_FAT16;
    else kind = KIND_FAT32;
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            rec   <= head;
            state <= head.truncated ? ST_FINISH : ST_MUL;
          end
        end
        ST_MUL: begin
          image    <= BYTES_W'(rec.total) * BYTES_W'(rec.sector);
          fat_prod <= 32'(rec.copies) * rec.fatsz;
          state    <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rec.sector == 16'd0) begin
            base_sum <= 32'(rec.reserved) + fat_prod;
            state    <= ST_DATA;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= root_num;
            div_req.divisor  <= rec.sector;
            state            <= ST_ROOT_WAIT;
          end
        end
        ST_ROOT_WAIT: begin
          if (div_rsp.done) begin
            base_sum <= 32'(rec.reserved) + fat_prod + div_rsp.quotient;
            state    <= ST_DATA;
          end
        end
        ST_DATA: begin
          datasec <= rec.total - base_sum;
          state   <= ST_CLUS;
        end
        ST_CLUS: begin
          if (rec.cluster == 8'd0) begin
            clusters <= '0;
            state    <= ST_FINISH;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= datasec;
            div_req.divisor  <= DIVISOR_W'(rec.cluster);
            state            <= ST_CLUS_WAIT;
          end
        end
        ST_CLUS_WAIT: begin
          if (div_rsp.done) begin
            clusters <= div_rsp.quotient;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            if (rec.truncated) begin
              signature_match <= 1'b0;
              plausible       <= 1'b0;
              truncated       <= 1'b1;
              fat_kind        <= KIND_UNKNOWN;
              sector_bytes    <= '0;
              cluster_sectors <= '0;
              reserved_count  <= '0;
              table_copies    <= '0;
              table_sectors   <= '0;
              sector_total    <= '0;
              image_bytes     <= '0;
              extent_length   <= '0;
            end else begin
              signature_match <= rec.sig;
              plausible       <= rec.plaus;
              truncated       <= 1'b0;
              fat_kind        <= kind;
              sector_bytes    <= rec.sector;
              cluster_sectors <= rec.cluster;
              reserved_count  <= rec.reserved;
              table_copies    <= rec.copies;
              table_sectors   <= rec.fatsz;
              sector_total    <= rec.total;
              image_bytes     <= image;
              extent_length   <= ext_w[BYTES_W-1:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
